@@ rtl/uibe_pkg.sv @@
// Shared types and constants of the UTF-8 invalid byte escaper.
package uibe_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0]  LEAD2_MIN = 8'hC2;
   localparam logic [7:0]  LEAD3_MIN = 8'hE0;
   localparam logic [7:0]  LEAD4_MIN = 8'hF0;
   localparam logic [7:0]  LEAD_MAX  = 8'hF5;
   localparam logic [15:0] CODE3_MIN = 16'h0800;
   localparam logic [15:0] SURR_LO   = 16'hD800;
   localparam logic [15:0] SURR_HI   = 16'hDFFF;
   localparam logic [20:0] CODE4_MIN = 21'h010000;
   localparam logic [20:0] CODE4_MAX = 21'h10FFFF;
   localparam logic [15:0] ESC_BASE  = 16'hE000;

   typedef struct packed {
      logic [7:0] data;
      logic       escape;
      logic       last;
      logic       invalid;
   } action_type;

endpackage

@@ rtl/uibe_front.sv @@
// Front part: buffers pending bytes and classifies each byte as passed or escaped.
module uibe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_in_last,
   input  logic                  q_full,
   output logic                  q_push,
   output uibe_pkg::action_type  q_data
);

   logic [7:0]  pend_ff [4];
   logic [7:0]  pend_in [4];
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  run_ff, run_in;
   logic        busy_ff, busy_in;
   logic        last_ff, last_in;
   logic        seen_ff, seen_in;

   logic [7:0]  head;
   logic [2:0]  need;
   logic [2:0]  lim;
   logic        cont;
   logic [15:0] code3;
   logic [20:0] code4;
   logic        seq_ok;
   logic        act_valid;
   logic        act_esc;
   logic        act_stop;

   always_comb begin
      head = pend_ff[0];
      if (head >= uibe_pkg::LEAD2_MIN && head <= uibe_pkg::LEAD_MAX) begin
         if (head < uibe_pkg::LEAD3_MIN) begin
            need = 3'd2;
         end else if (head < uibe_pkg::LEAD4_MIN) begin
            need = 3'd3;
         end else begin
            need = 3'd4;
         end
      end else begin
         need = 3'd0;
      end
      lim = (cnt_ff < need) ? cnt_ff : need;
      cont = 1'b1;
      for (int i = 1; i < 4; i++) begin
         if (3'(i) < lim && pend_ff[i][7:6] != 2'b10) begin
            cont = 1'b0;
         end
      end
      code3 = {head[3:0], pend_ff[1][5:0], pend_ff[2][5:0]};
      code4 = {head[2:0], pend_ff[1][5:0], pend_ff[2][5:0], pend_ff[3][5:0]};
      if (need == 3'd2) begin
         seq_ok = 1'b1;
      end else if (need == 3'd3) begin
         seq_ok = code3 >= uibe_pkg::CODE3_MIN &&
                  !(code3 >= uibe_pkg::SURR_LO && code3 <= uibe_pkg::SURR_HI);
      end else begin
         seq_ok = code4 >= uibe_pkg::CODE4_MIN && code4 <= uibe_pkg::CODE4_MAX;
      end

      act_valid = 1'b0;
      act_esc   = 1'b0;
      act_stop  = 1'b0;
      run_in    = run_ff;
      if (cnt_ff == 3'd0) begin
         act_stop = 1'b1;
      end else if (run_ff != 2'd0) begin
         act_valid = 1'b1;
         run_in    = run_ff - 2'd1;
      end else if (!head[7]) begin
         act_valid = 1'b1;
      end else if (need == 3'd0 || !cont) begin
         act_valid = 1'b1;
         act_esc   = 1'b1;
      end else if (cnt_ff < need) begin
         if (last_ff) begin
            act_valid = 1'b1;
            act_esc   = 1'b1;
         end else begin
            act_stop = 1'b1;
         end
      end else if (seq_ok) begin
         act_valid = 1'b1;
         run_in    = 2'(need - 3'd1);
      end else begin
         act_valid = 1'b1;
         act_esc   = 1'b1;
      end

      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      last_in = last_ff;
      seen_in = seen_ff;
      q_push  = 1'b0;
      if (!busy_ff) begin
         run_in = run_ff;
         if (req_push) begin
            pend_in[cnt_ff[1:0]] = req_in_byte;
            cnt_in  = cnt_ff + 3'd1;
            last_in = req_in_last;
            busy_in = 1'b1;
         end
      end else if (act_stop) begin
         busy_in = 1'b0;
         if (last_ff) begin
            cnt_in  = 3'd0;
            last_in = 1'b0;
            seen_in = 1'b0;
         end
      end else if (act_valid && !q_full) begin
         q_push = 1'b1;
         for (int i = 0; i < 3; i++) begin
            pend_in[i] = pend_ff[i + 1];
         end
         cnt_in = cnt_ff - 3'd1;
         if (act_esc) begin
            seen_in = 1'b1;
         end
      end else begin
         run_in = run_ff;
      end

      q_data.data    = head;
      q_data.escape  = act_esc;
      q_data.last    = last_ff && cnt_ff == 3'd1;
      q_data.invalid = seen_ff | act_esc;
   end

   assign req_full = busy_ff;

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         cnt_ff  <= 3'd0;
         run_ff  <= 2'd0;
         busy_ff <= 1'b0;
         last_ff <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         busy_ff <= busy_in;
         last_ff <= last_in;
         seen_ff <= seen_in;
      end
   end

   a_run_covered: assert property (@(posedge clock) disable iff (reset)
      run_ff != 2'd0 |-> busy_ff && cnt_ff >= 3'(run_ff))
      else $error("passthrough run exceeds buffered bytes");

   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff <= 3'd3)
      else $error("idle with no room for a new byte");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      busy_ff && last_ff && act_stop |=> cnt_ff == 3'd0 && !seen_ff)
      else $error("string end left state behind");

endmodule

@@ rtl/uibe_queue.sv @@
// Short queue of classified bytes between the front and the back part.
module uibe_queue #(
   parameter int DEPTH = uibe_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  uibe_pkg::action_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output uibe_pkg::action_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   uibe_pkg::action_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("item pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("item popped from an empty queue");

endmodule

@@ rtl/uibe_back.sv @@
// Back part: expands escapes into three bytes and drives the result register.
module uibe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  report_only,
   input  logic                  q_empty,
   input  uibe_pkg::action_type  q_head,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_last,
   output logic                  rsp_any_invalid
);

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        inv_ff, inv_in;
   logic [1:0]  sub_ff, sub_in;
   logic        out_free;
   logic        load;
   logic [15:0] esc_code;

   always_comb begin
      out_free = !out_valid_ff || rsp_pop;
      esc_code = uibe_pkg::ESC_BASE + {8'h00, q_head.data};
      load     = 1'b0;
      q_pop    = 1'b0;
      sub_in   = sub_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      inv_in   = inv_ff;
      if (!q_empty) begin
         if (report_only) begin
            if (!q_head.last) begin
               q_pop = 1'b1;
            end else if (out_free) begin
               q_pop   = 1'b1;
               load    = 1'b1;
               byte_in = 8'h00;
               last_in = 1'b1;
               inv_in  = q_head.invalid;
            end
         end else if (out_free) begin
            load = 1'b1;
            if (!q_head.escape) begin
               q_pop   = 1'b1;
               byte_in = q_head.data;
               last_in = q_head.last;
               inv_in  = q_head.last & q_head.invalid;
            end else begin
               last_in = 1'b0;
               inv_in  = 1'b0;
               case (sub_ff)
                  2'd0: begin
                     byte_in = {4'hE, esc_code[15:12]};
                     sub_in  = 2'd1;
                  end
                  2'd1: begin
                     byte_in = {2'b10, esc_code[11:6]};
                     sub_in  = 2'd2;
                  end
                  default: begin
                     byte_in = {2'b10, esc_code[5:0]};
                     sub_in  = 2'd0;
                     q_pop   = 1'b1;
                     last_in = q_head.last;
                     inv_in  = q_head.last & q_head.invalid;
                  end
               endcase
            end
         end
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_out_last    = last_ff;
   assign rsp_any_invalid = inv_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      inv_ff  <= inv_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
         sub_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         sub_ff       <= sub_in;
      end
   end

   a_sub_on_escape: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 2'd0 |-> !q_empty && q_head.escape && !report_only)
      else $error("escape step without an escape item at the head");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 2'd3)
      else $error("escape step out of range");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(byte_ff))
      else $error("stalled result changed");

endmodule

@@ rtl/utf8_invalid_byte_escaper_core.sv @@
// Top level of the UTF-8 invalid byte escaper.
//
// Input channel: bytes of a string enter on req_in_byte with req_in_last on
// the final byte; an item is taken when req_push is high and req_full low.
// Result channel: the oldest result sits on the rsp_ ports while rsp_empty is
// low and leaves when rsp_pop is high. Valid UTF-8 passes unchanged; a byte
// that cannot start a valid sequence becomes three bytes encoding 0xE000 plus
// the byte. rsp_any_invalid is meaningful with rsp_out_last.
// csr_report_only set to one suppresses all bytes and yields a single flag
// result per string; write it only while the block is idle.
// The front part accepts an item, classifies its buffered bytes one at a
// time and then finishes before it takes the next item. The back part
// emits one result per cycle while the queue is not empty and the receiver
// takes them, three bytes per escape; a four-entry queue separates the two.
// Bytes go from the pending buffer through the queue to the result register.
// Reset empties the buffer, the queue and the register and clears the flag.
// A stalled receiver holds the result register; the queue fills, then the
// front part stops and req_full stays high.
module utf8_invalid_byte_escaper_core #(
   parameter int QUEUE_DEPTH = uibe_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_any_invalid,
   input  logic       csr_write_enable,
   input  logic       csr_report_only
);

   logic                 report_only_ff;
   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_empty;
   uibe_pkg::action_type q_push_data;
   uibe_pkg::action_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         report_only_ff <= 1'b0;
      end else if (csr_write_enable) begin
         report_only_ff <= csr_report_only;
      end
   end

   uibe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   uibe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   uibe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .report_only     (report_only_ff),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_last    (rsp_out_last),
      .rsp_any_invalid (rsp_any_invalid)
   );

endmodule
